>>> rtl/b64fs_pkg.sv
package b64fs_pkg;

  localparam int unsigned SextetW = 6;
  localparam int unsigned CharW = 8;
  localparam int unsigned SizeW = 16;

  localparam logic [CharW-1:0] CharPlus = 8'h2B;
  localparam logic [CharW-1:0] CharUnder = 8'h5F;
  localparam logic [CharW-1:0] CharNul = 8'h00;

  typedef enum logic [2:0] {
    PH_FIRST  = 3'b001,
    PH_SECOND = 3'b010,
    PH_THIRD  = 3'b100
  } phase_t;

  // one queued request: up to two sextets, then an optional terminator
  typedef struct packed {
    logic [1:0]         n_chars;
    logic [SextetW-1:0] sx0;
    logic [SextetW-1:0] sx1;
    logic               has_end;
  } job_t;

  function automatic logic [CharW-1:0] sextet_to_char(input logic [SextetW-1:0] s);
    logic [CharW-1:0] v;
    v = {2'b00, s};
    if (s < 6'd26) begin
      return v + 8'h41;
    end else if (s < 6'd52) begin
      return v - 8'd26 + 8'h61;
    end else if (s < 6'd62) begin
      return v - 8'd52 + 8'h30;
    end else if (s == 6'd62) begin
      return CharPlus;
    end else begin
      return CharUnder;
    end
  endfunction

endpackage

>>> rtl/b64fs_front.sv
module b64fs_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_valid,
  input  logic [15:0]              cfg_buffer_size,
  input  logic                     in_accept,
  input  logic [7:0]               in_data_byte,
  input  logic                     in_last_byte,
  output logic                     push,
  output b64fs_pkg::job_t          push_job
);
  import b64fs_pkg::*;

  logic [SizeW-1:0] size_r;
  logic [SizeW-1:0] emitted_r, emitted_nxt;
  logic [3:0]       held_r, held_nxt;
  phase_t           phase_r, phase_nxt;

  logic [SextetW-1:0] c0, c1;
  logic [1:0]         req;
  logic [SizeW-1:0]   limit;
  logic               ok_one, ok_two;
  logic [1:0]         pass;

  always_comb begin
    c0 = in_data_byte[7:2];
    c1 = {in_data_byte[1:0], 4'b0000};
    req = in_last_byte ? 2'd2 : 2'd1;
    held_nxt = {2'b00, in_data_byte[1:0]};
    phase_nxt = PH_SECOND;
    case (phase_r)
      PH_SECOND: begin
        c0 = {held_r[1:0], in_data_byte[7:4]};
        c1 = {in_data_byte[3:0], 2'b00};
        held_nxt = in_data_byte[3:0];
        phase_nxt = PH_THIRD;
      end
      PH_THIRD: begin
        c0 = {held_r, in_data_byte[7:6]};
        c1 = in_data_byte[5:0];
        req = 2'd2;
        held_nxt = 4'd0;
        phase_nxt = PH_FIRST;
      end
      default: begin
      end
    endcase
    if (in_last_byte) begin
      held_nxt = 4'd0;
      phase_nxt = PH_FIRST;
    end

    limit = size_r - 16'd1;
    ok_one = (size_r != '0) && (emitted_r < limit);
    ok_two = (size_r != '0) && (({1'b0, emitted_r} + 17'd1) < {1'b0, limit});
    if (!ok_one) begin
      pass = 2'd0;
    end else if (!ok_two) begin
      pass = 2'd1;
    end else begin
      pass = req;
    end
    emitted_nxt = in_last_byte ? '0 : emitted_r + {14'd0, pass};

    push_job.n_chars = pass;
    push_job.sx0 = c0;
    push_job.sx1 = c1;
    push_job.has_end = in_last_byte && (size_r != '0);
    push = in_accept && ((pass != 2'd0) || push_job.has_end);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= 16'hFFFF;
      emitted_r <= '0;
      held_r <= '0;
      phase_r <= PH_FIRST;
    end else begin
      if (cfg_valid) begin
        size_r <= cfg_buffer_size;
      end
      if (in_accept) begin
        emitted_r <= emitted_nxt;
        held_r <= held_nxt;
        phase_r <= phase_nxt;
      end
    end
  end

endmodule

>>> rtl/b64fs_fifo.sv
module b64fs_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  b64fs_pkg::job_t push_job,
  input  logic            pop,
  output logic            full,
  output logic            not_empty,
  output b64fs_pkg::job_t head_job
);
  import b64fs_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] Full = CntW'(DEPTH);

  job_t            mem_r [DEPTH];
  logic [PtrW-1:0] wr_r, rd_r;
  logic [CntW-1:0] cnt_r;

  assign full = (cnt_r == Full);
  assign not_empty = (cnt_r != '0);
  assign head_job = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0;
      rd_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == LastPtr) ? '0 : wr_r + PtrW'(1);
      end
      if (pop) begin
        rd_r <= (rd_r == LastPtr) ? '0 : rd_r + PtrW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CntW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CntW'(1);
      end
    end
  end

endmodule

>>> rtl/b64fs_back.sv
module b64fs_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            job_valid,
  input  b64fs_pkg::job_t job,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_char,
  output logic            out_is_end
);
  import b64fs_pkg::*;

  logic [1:0]       pos_r;
  logic             valid_r;
  logic [CharW-1:0] char_r;
  logic             end_r;

  logic             load;
  logic             is_char;
  logic             last_item;
  logic [CharW-1:0] char_nxt;

  always_comb begin
    load = job_valid && (!valid_r || out_ready);
    is_char = (pos_r < job.n_chars);
    last_item = is_char ? ((pos_r + 2'd1 == job.n_chars) && !job.has_end) : 1'b1;
    char_nxt = is_char ? sextet_to_char((pos_r == 2'd0) ? job.sx0 : job.sx1) : CharNul;
    pop = load && last_item;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      char_r <= char_nxt;
      end_r <= !is_char;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      valid_r <= 1'b0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        pos_r <= last_item ? 2'd0 : pos_r + 2'd1;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = valid_r;
  assign out_char = char_r;
  assign out_is_end = end_r;

endmodule

>>> rtl/base64_filename_safe_encoder.sv
// channel | direction | handshake             | payload
// in      | input     | in_valid / in_ready   | in_data_byte, in_last_byte
// out     | output    | out_valid / out_ready | out_char, out_is_end
// cfg     | input     | cfg_valid / cfg_ready | cfg_buffer_size
// one byte is taken per cycle while the request queue has room
// one result leaves per cycle from the output register while out_ready is high and a job is queued
// sustained rate is set by the output register: 4 characters per 3 bytes, queued before output
// reset is synchronous, active low, and clears phase, count, queue and output valid
// cfg is always ready; a stalled output fills the queue and then holds in_ready low
module base64_filename_safe_encoder #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_buffer_size,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_char,
  output logic        out_is_end
);
  import b64fs_pkg::*;

  logic q_full, q_not_empty, push, pop;
  job_t push_job, head_job;

  assign cfg_ready = 1'b1;
  assign in_ready = !q_full;

  b64fs_front u_front (
    .clk,
    .rst_n,
    .cfg_valid,
    .cfg_buffer_size,
    .in_accept(in_valid && in_ready),
    .in_data_byte,
    .in_last_byte,
    .push,
    .push_job
  );

  b64fs_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk,
    .rst_n,
    .push,
    .push_job,
    .pop,
    .full(q_full),
    .not_empty(q_not_empty),
    .head_job
  );

  b64fs_back u_back (
    .clk,
    .rst_n,
    .job_valid(q_not_empty),
    .job(head_job),
    .pop,
    .out_valid,
    .out_ready,
    .out_char,
    .out_is_end
  );

endmodule

>>> rtl/b64fs_checker.sv
module b64fs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       out_is_end
);

  // terminator carries a nul
  a_end_nul: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_end |-> out_char == 8'h00)
    else $error("terminator with non-nul char");

  // characters come from A-Z, a-z, 0-9, '+' and '_'
  a_alphabet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_end |->
      (out_char >= 8'h41 && out_char <= 8'h5A) || (out_char >= 8'h61 && out_char <= 8'h7A) ||
      (out_char >= 8'h30 && out_char <= 8'h39) || out_char == 8'h2B || out_char == 8'h5F)
    else $error("character outside alphabet");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_is_end))
    else $error("stalled result changed");

  // reset empties the output
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind base64_filename_safe_encoder b64fs_checker u_checker (
  .clk,
  .rst_n,
  .out_valid,
  .out_ready,
  .out_char,
  .out_is_end
);
